### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; no dependencies.
package spq_pkg;

  // Number of storage cells in the row
  localparam int unsigned CAPACITY = 16;
  // Width of the live-entry count, which must also hold CAPACITY itself
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned OccW = 5;

  // Command codes on op_i
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell in the row
  typedef struct packed {
    logic                    ins;    // insert enabled (queue not full)
    logic                    del;    // delete enabled (queue not empty)
    logic signed [DataW-1:0] value;
  } cell_cmd_t;

  // What a cell shows to the next cell toward the back
  typedef struct packed {
    logic                    live;   // cell holds a stored entry
    logic                    gt;     // stored entry is greater than the new value
    logic signed [DataW-1:0] data;
  } cell_link_t;

endpackage

### hw/rtl/spq_cell.sv
// One storage cell of the sorted priority queue row.
// Depends on spq_pkg for the command and link types.
module spq_cell (
  input  logic                           clk_i,
  input  spq_pkg::cell_cmd_t             cmd_i,
  input  logic                           live_i,
  input  spq_pkg::cell_link_t            prev_i,
  input  logic signed [spq_pkg::DataW-1:0] next_data_i,
  output spq_pkg::cell_link_t            link_o
);
  import spq_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic                    gt;

  // New value goes in front of this entry
  assign gt = live_i && (cmd_i.value < data_q);

  assign link_o.live = live_i;
  assign link_o.gt   = gt;
  assign link_o.data = data_q;

  // Insert shifts the tail back by one; delete pulls every entry forward
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (prev_i.gt) begin
        data_d = prev_i.data;
      end else if (gt || (!live_i && prev_i.live)) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell row, count and result register.
// Depends on spq_pkg and spq_cell.

// Holds up to CAPACITY signed 32-bit words in ascending order in a row of
// cells, one word per cell. Every command (insert or delete-smallest) is
// done by the row at once: all cells compare the new word against their own
// in parallel and each takes its neighbor's word, the new word, or keeps its
// own, so the row shifts as a unit. One command is accepted per cycle; the
// result word is registered and the input is stalled only while a result
// waits on a stalled output. Equal words leave in arrival order. An insert
// into a full queue returns status full, a delete from an empty queue
// returns status empty; neither changes the contents.
module sorted_priority_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic signed [spq_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [spq_pkg::DataW-1:0] removed_value_o,
  output logic [spq_pkg::OccW-1:0]         occupancy_o
);
  import spq_pkg::*;

  logic [CntW-1:0]         count_q, count_d;
  logic                    accept;
  logic                    full, empty;
  cell_cmd_t               cmd;
  logic [CAPACITY-1:0]     live;
  cell_link_t              link [CAPACITY];
  status_e                 status_d, status_q;
  logic signed [DataW-1:0] removed_d, removed_q;
  logic [OccW-1:0]         occ_q;
  logic                    out_valid_q;

  // Handshake: a new word enters whenever the result register is free or drains
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  assign cmd.ins   = accept && (op_i == OP_INSERT) && !full;
  assign cmd.del   = accept && (op_i == OP_DELETE) && !empty;
  assign cmd.value = value_i;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t              prev;
    logic signed [DataW-1:0] next_data;

    assign live[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev = '{live: 1'b1, gt: 1'b0, data: '0};
    end else begin : g_body
      assign prev = link[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_data = link[i].data;
    end else begin : g_mid
      assign next_data = link[i+1].data;
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .live_i      (live[i]),
      .prev_i      (prev),
      .next_data_i (next_data),
      .link_o      (link[i])
    );
  end

  // Count and result
  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    removed_d = '0;
    if (op_i == OP_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d   = count_q - 1'b1;
        removed_d = link[0].data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      occ_q     <= OccW'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign occupancy_o     = occ_q;

endmodule
